FILE: rtl/blg_pkg.sv
package blg_pkg;

	// widths of the configuration write channel
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// item opcodes
	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_ACK    = 1'b1
	} opcode_t;

	// advisory codes
	typedef enum logic [1:0] {
		ADV_NONE     = 2'd0,
		ADV_LOW      = 2'd1,
		ADV_VERY_LOW = 2'd2
	} advisory_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SAMPLE_INTERVAL   = 3'd0,
		CFG_LOW_PERCENT       = 3'd1,
		CFG_LOW_REARM         = 3'd2,
		CFG_VERY_LOW_PERCENT  = 3'd3,
		CFG_VERY_LOW_REARM    = 3'd4,
		CFG_CRITICAL_MV       = 3'd5,
		CFG_CONFIRM_SAMPLES   = 3'd6
	} cfg_index_t;

	// reset values of the configuration registers
	localparam logic [15:0] RST_SAMPLE_INTERVAL  = 16'd1000;
	localparam logic [6:0]  RST_LOW_PERCENT      = 7'd20;
	localparam logic [6:0]  RST_LOW_REARM        = 7'd25;
	localparam logic [6:0]  RST_VERY_LOW_PERCENT = 7'd10;
	localparam logic [6:0]  RST_VERY_LOW_REARM   = 7'd15;
	localparam logic [14:0] RST_CRITICAL_MV      = 15'd3300;
	localparam logic [7:0]  RST_CONFIRM_SAMPLES  = 8'd3;

	typedef struct packed {
		logic [15:0] sample_interval_ms;
		logic [6:0]  low_percent;
		logic [6:0]  low_rearm_percent;
		logic [6:0]  very_low_percent;
		logic [6:0]  very_low_rearm_percent;
		logic [14:0] critical_voltage_mv;
		logic [7:0]  critical_confirm_samples;
	} cfg_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [31:0]        now_ms;
		logic               charging;
		logic signed [7:0]  charge_pct;
		logic signed [15:0] batt_mv;
	} item_t;

	typedef struct packed {
		logic      sampled;
		logic      crit_confirm;
		advisory_t advisory;
	} result_t;

endpackage

FILE: rtl/blg_item_if.sv
interface blg_item_if;
	import blg_pkg::*;

	logic               valid;
	logic               ready;
	logic               opcode;
	logic [31:0]        now_ms;
	logic               charging;
	logic signed [7:0]  charge_pct;
	logic signed [15:0] batt_mv;

	modport source (
		output valid, opcode, now_ms, charging, charge_pct, batt_mv,
		input  ready
	);
	modport sink (
		input  valid, opcode, now_ms, charging, charge_pct, batt_mv,
		output ready
	);
endinterface

FILE: rtl/blg_result_if.sv
interface blg_result_if;
	logic       valid;
	logic       ready;
	logic       sampled;
	logic       crit_confirm;
	logic [1:0] advisory;

	modport source (
		output valid, sampled, crit_confirm, advisory,
		input  ready
	);
	modport sink (
		input  valid, sampled, crit_confirm, advisory,
		output ready
	);
endinterface

FILE: rtl/blg_cfg_if.sv
interface blg_cfg_if;
	import blg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

FILE: rtl/blg_core.sv
module blg_core
	import blg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic        have_sample_q;
	logic [31:0] last_time_q;
	logic        low_armed_q;
	logic        very_low_armed_q;
	advisory_t   pending_q;
	logic [7:0]  confirm_q;

	logic        have_sample_d;
	logic [31:0] last_time_d;
	logic        low_armed_d;
	logic        very_low_armed_d;
	advisory_t   pending_d;
	logic [7:0]  confirm_d;

	logic [31:0] elapsed;
	logic        take;
	logic [6:0]  lvl;
	logic        lvl_known;
	logic        la_rearm;
	logic        vla_rearm;
	logic        mv_critical;
	logic [7:0]  count_next;
	logic        crit;

	// interval check with wrapping time
	assign elapsed = item.now_ms - last_time_q;
	assign take    = (item.opcode == OP_UPDATE) &&
		(!have_sample_q || (elapsed >= {16'd0, cfg.sample_interval_ms}));

	// level and voltage comparisons
	assign lvl       = item.charge_pct[6:0];
	assign lvl_known = !item.charge_pct[7];
	assign la_rearm  = low_armed_q || (lvl > cfg.low_rearm_percent);
	assign vla_rearm = very_low_armed_q || (lvl > cfg.very_low_rearm_percent);
	assign mv_critical = !item.batt_mv[15] &&
		(item.batt_mv[14:0] <= cfg.critical_voltage_mv);
	assign count_next = (confirm_q < cfg.critical_confirm_samples) ?
		confirm_q + 8'd1 : confirm_q;

	// next state and result of one item
	always_comb begin
		have_sample_d    = have_sample_q;
		last_time_d      = last_time_q;
		low_armed_d      = low_armed_q;
		very_low_armed_d = very_low_armed_q;
		pending_d        = pending_q;
		confirm_d        = confirm_q;
		crit             = 1'b0;
		if (item.opcode == OP_ACK) begin
			pending_d = ADV_NONE;
		end else if (take) begin
			have_sample_d = 1'b1;
			last_time_d   = item.now_ms;
			if (item.charging) begin
				low_armed_d      = 1'b1;
				very_low_armed_d = 1'b1;
				pending_d        = ADV_NONE;
				confirm_d        = 8'd0;
			end else begin
				// advisory latches with hysteresis, very low first
				if (lvl_known) begin
					low_armed_d      = la_rearm;
					very_low_armed_d = vla_rearm;
					if ((lvl <= cfg.very_low_percent) && vla_rearm) begin
						very_low_armed_d = 1'b0;
						low_armed_d      = 1'b0;
						pending_d        = ADV_VERY_LOW;
					end else if ((lvl <= cfg.low_percent) && la_rearm) begin
						low_armed_d = 1'b0;
						if (pending_q != ADV_VERY_LOW) begin
							pending_d = ADV_LOW;
						end
					end
				end
				// consecutive critical sample counter
				if (mv_critical) begin
					confirm_d = count_next;
					crit      = (count_next >= cfg.critical_confirm_samples);
				end else begin
					confirm_d = 8'd0;
				end
			end
		end
	end

	assign result.sampled      = take;
	assign result.crit_confirm = crit;
	assign result.advisory     = pending_d;

	// guard state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_sample_q    <= 1'b0;
			last_time_q      <= 32'd0;
			low_armed_q      <= 1'b1;
			very_low_armed_q <= 1'b1;
			pending_q        <= ADV_NONE;
			confirm_q        <= 8'd0;
		end else if (step) begin
			have_sample_q    <= have_sample_d;
			last_time_q      <= last_time_d;
			low_armed_q      <= low_armed_d;
			very_low_armed_q <= very_low_armed_d;
			pending_q        <= pending_d;
			confirm_q        <= confirm_d;
		end
	end

endmodule

FILE: rtl/battery_level_guard.sv
// Battery level guard: takes update items (time, charging flag, charge percent, voltage) and
// acknowledge items, and returns one result item per input item with the sampled flag, the
// critical-voltage confirmation and the pending advisory. An item is registered on entry and
// its result is computed from the input register into the output register. One item can be
// taken each cycle unless the output stalls; the single state update between the input
// register and the output register sets that rate. Configuration writes are always accepted
// and should only be issued while no item is in flight.
module battery_level_guard
	import blg_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	blg_item_if.sink      item_in,
	blg_result_if.source  result_out,
	blg_cfg_if.sink       cfg
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t result_c;
	logic    adv_s1;
	logic    in_fire;

	// pipeline moves when the output register is free or being drained
	assign adv_s1        = !valid_s2 || result_out.ready;
	assign item_in.ready = !valid_s1 || adv_s1;
	assign in_fire       = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval_ms       <= RST_SAMPLE_INTERVAL;
			cfg_q.low_percent              <= RST_LOW_PERCENT;
			cfg_q.low_rearm_percent        <= RST_LOW_REARM;
			cfg_q.very_low_percent         <= RST_VERY_LOW_PERCENT;
			cfg_q.very_low_rearm_percent   <= RST_VERY_LOW_REARM;
			cfg_q.critical_voltage_mv      <= RST_CRITICAL_MV;
			cfg_q.critical_confirm_samples <= RST_CONFIRM_SAMPLES;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.index))
				CFG_SAMPLE_INTERVAL:  cfg_q.sample_interval_ms       <= cfg.data;
				CFG_LOW_PERCENT:      cfg_q.low_percent              <= cfg.data[6:0];
				CFG_LOW_REARM:        cfg_q.low_rearm_percent        <= cfg.data[6:0];
				CFG_VERY_LOW_PERCENT: cfg_q.very_low_percent         <= cfg.data[6:0];
				CFG_VERY_LOW_REARM:   cfg_q.very_low_rearm_percent   <= cfg.data[6:0];
				CFG_CRITICAL_MV:      cfg_q.critical_voltage_mv      <= cfg.data[14:0];
				CFG_CONFIRM_SAMPLES:  cfg_q.critical_confirm_samples <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode     <= opcode_t'(item_in.opcode);
			item_s1.now_ms     <= item_in.now_ms;
			item_s1.charging   <= item_in.charging;
			item_s1.charge_pct <= item_in.charge_pct;
			item_s1.batt_mv    <= item_in.batt_mv;
		end
	end

	// guard state and per-item logic
	blg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	assign result_out.valid        = valid_s2;
	assign result_out.sampled      = result_s2.sampled;
	assign result_out.crit_confirm = result_s2.crit_confirm;
	assign result_out.advisory     = result_s2.advisory;

endmodule
